### design/sss_pkg.sv
package sss_pkg;

    // Field and datapath widths
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 32;
    localparam int GAIN_FRAC = 16;
    localparam int HW_W      = 5;
    localparam int SPAN_W    = 6;
    localparam int SUM_W     = 38;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults
    localparam int DEF_MAX_HALF_WIDTH = 31;
    localparam int DEF_RING_DEPTH     = 64;
    localparam int DEF_INDEX_BITS     = 16;

    // Register reset values
    localparam logic [HW_W-1:0]   DEF_HALF_WIDTH = '0;
    localparam logic [GAIN_W-1:0] DEF_GAIN       = 32'h0001_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 1'd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Divider: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [DATA_W-1:0] power;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] smoothed;
        logic              end_of_run;
    } t_out_item;

    // Scaled bin handed from front to back
    typedef struct packed {
        logic [DATA_W-1:0] scaled;
        logic              is_last;
        logic [HW_W-1:0]   half;
    } t_task;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [SPAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ISSUE,
        B_DROP,
        B_WRITE,
        B_CHECK,
        B_DIV,
        B_OUT,
        B_SHRINK,
        B_SUB
    } t_back_state;

endpackage

### design/sss_ram.sv
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sss_div.sv
module sss_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sss_pkg::t_div_req i_req,
    output sss_pkg::t_div_rsp o_rsp
);
    import sss_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [SPAN_W-1:0]    r_rem;
    logic [SPAN_W-1:0]    r_dvs;

    logic [SPAN_W:0]      trial;
    logic                 fits;
    logic [SPAN_W:0]      diff;
    logic [SPAN_W-1:0]    n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
        n_rem = fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[DATA_W-1:0];

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

endmodule

### design/sss_queue.sv
module sss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sss_pkg::t_task i_task,
    output logic           o_full,
    output logic           o_valid,
    output sss_pkg::t_task o_task,
    input  logic           i_pop
);
    import sss_pkg::*;

    t_task             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    // Advance a pointer around the queue
    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_task  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

endmodule

### design/sss_front.sv
module sss_front #(
    parameter int MAX_HALF_WIDTH = sss_pkg::DEF_MAX_HALF_WIDTH,
    parameter int RING_DEPTH     = sss_pkg::DEF_RING_DEPTH,
    parameter int INDEX_BITS     = sss_pkg::DEF_INDEX_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  sss_pkg::t_in_item           i_item,
    input  logic [sss_pkg::HW_W-1:0]    i_half_width,
    input  logic [sss_pkg::GAIN_W-1:0]  i_gain,
    output logic                        o_push,
    output sss_pkg::t_task              o_task,
    input  logic                        i_full
);
    import sss_pkg::*;

    // Largest usable half width: ring size and index range bound it too
    localparam int          RING_HALF = (RING_DEPTH - 1) / 2;
    localparam int          CAP_A     = (MAX_HALF_WIDTH < RING_HALF) ? MAX_HALF_WIDTH
                                                                     : RING_HALF;
    localparam logic [63:0] IDX_HALF  = ((64'd1 << INDEX_BITS) - 64'd2) / 64'd2;
    localparam logic [63:0] N_CAP     = (64'(CAP_A) < IDX_HALF) ? 64'(CAP_A) : IDX_HALF;

    logic                    r_first;
    logic [HW_W-1:0]         r_run_half;

    logic                    r_s1_valid;
    logic [DATA_W-1:0]       r_s1_power;
    logic                    r_s1_last;
    logic [HW_W-1:0]         r_s1_half;

    logic                    r_s2_valid;
    logic [DATA_W-1:0]       r_s2_scaled;
    logic                    r_s2_last;
    logic [HW_W-1:0]         r_s2_half;

    logic [HW_W-1:0]         hw_cap;
    logic [HW_W-1:0]         clipped;
    logic [HW_W-1:0]         half_now;
    logic [2*DATA_W-1:0]     product;
    logic [DATA_W-1:0]       scaled;
    logic                    push;
    logic                    s2_free;
    logic                    s1_move;
    logic                    s1_free;
    logic                    accept;

    // Latch the clipped half width at the first bin of a spectrum
    always_comb begin
        hw_cap   = HW_W'(N_CAP);
        clipped  = (i_half_width > hw_cap) ? hw_cap : i_half_width;
        half_now = r_first ? clipped : r_run_half;
    end

    // Scale by the Q16.16 gain, saturate to the bin width
    always_comb begin
        product = 64'(r_s1_power) * 64'(i_gain);
        scaled  = (|product[2*DATA_W-1:DATA_W+GAIN_FRAC]) ? '1
                : product[DATA_W+GAIN_FRAC-1:GAIN_FRAC];
    end

    // Flow control through the two stages
    always_comb begin
        push    = r_s2_valid && !i_full;
        s2_free = !r_s2_valid || push;
        s1_move = r_s1_valid && s2_free;
        s1_free = !r_s1_valid || s1_move;
        accept  = i_valid && s1_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_run_half <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_first <= i_item.is_last;
                if (r_first) begin
                    r_run_half <= clipped;
                end
            end
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= s1_move;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_power <= i_item.power;
            r_s1_last  <= i_item.is_last;
            r_s1_half  <= half_now;
        end
        if (s1_move) begin
            r_s2_scaled <= scaled;
            r_s2_last   <= r_s1_last;
            r_s2_half   <= r_s1_half;
        end
    end

    assign o_stall        = !s1_free;
    assign o_push         = push;
    assign o_task.scaled  = r_s2_scaled;
    assign o_task.is_last = r_s2_last;
    assign o_task.half    = r_s2_half;

endmodule

### design/sss_back.sv
module sss_back #(
    parameter int RING_DEPTH = sss_pkg::DEF_RING_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sss_pkg::t_task     i_q_task,
    output logic               o_q_pop,
    output sss_pkg::t_div_req  o_div_req,
    input  sss_pkg::t_div_rsp  i_div_rsp,
    output logic               o_valid,
    input  logic               i_stall,
    output sss_pkg::t_out_item o_item
);
    import sss_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int XW = SPAN_W + 1;

    t_back_state       r_state;
    t_back_state       n_state;

    logic [DATA_W-1:0] r_scaled,  n_scaled;
    logic              r_last,    n_last;
    logic [HW_W-1:0]   r_n,       n_n;
    logic [AW-1:0]     r_ws,      n_ws;
    logic [SPAN_W-1:0] r_fill,    n_fill;
    logic [SUM_W-1:0]  r_sum,     n_sum;
    logic              r_flush,   n_flush;
    logic [HW_W-1:0]   r_left,    n_left;
    logic              r_res_end, n_res_end;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,     n_out;

    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] lag;
    logic [XW-1:0]     ws_x;
    logic [XW-1:0]     lag_x;
    logic [XW-1:0]     back_x;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;
    logic              we;
    logic              out_free;
    logic [SPAN_W-1:0] keep;

    // Ring of scaled bins
    sss_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_ws),
        .i_wdata(r_scaled),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Ring slot a given distance behind the write slot
    always_comb begin
        span   = {r_n, 1'b1};
        lag    = (r_state == B_ISSUE) ? span : r_fill;
        ws_x   = XW'(r_ws);
        lag_x  = XW'(lag);
        back_x = (ws_x >= lag_x) ? ws_x - lag_x : ws_x + XW'(RING_DEPTH) - lag_x;
        raddr  = back_x[AW-1:0];
        keep   = {1'b0, r_left} + {1'b0, r_n};
        out_free = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: drop, insert, emit the center, then flush at the last bin
    always_comb begin
        n_state     = r_state;
        n_scaled    = r_scaled;
        n_last      = r_last;
        n_n         = r_n;
        n_ws        = r_ws;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_flush     = r_flush;
        n_left      = r_left;
        n_res_end   = r_res_end;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        we          = 1'b0;
        o_q_pop     = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_sum;
        o_div_req.divisor  = r_fill;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_scaled = i_q_task.scaled;
                    n_last   = i_q_task.is_last;
                    n_n      = i_q_task.half;
                    n_state  = B_ISSUE;
                end
            end
            B_ISSUE: begin
                n_state = (r_fill == span) ? B_DROP : B_WRITE;
            end
            B_DROP: begin
                n_sum   = r_sum - SUM_W'(rdata);
                n_state = B_WRITE;
            end
            B_WRITE: begin
                we      = 1'b1;
                n_sum   = r_sum + SUM_W'(r_scaled);
                n_ws    = (r_ws == AW'(RING_DEPTH - 1)) ? '0 : r_ws + 1'b1;
                n_fill  = (r_fill == span) ? r_fill : r_fill + 1'b1;
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (r_fill > {1'b0, r_n}) begin
                    o_div_req.start = 1'b1;
                    n_res_end = r_last && (r_n == '0);
                    n_flush   = 1'b0;
                    n_state   = B_DIV;
                end else if (r_last) begin
                    n_flush = 1'b1;
                    n_left  = r_fill[HW_W-1:0];
                    n_state = B_SHRINK;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_SHRINK: begin
                if (r_fill > keep) begin
                    n_state = B_SUB;
                end else begin
                    o_div_req.start = 1'b1;
                    n_res_end = r_left == HW_W'(1);
                    n_state   = B_DIV;
                end
            end
            B_SUB: begin
                n_sum   = r_sum - SUM_W'(rdata);
                n_fill  = r_fill - 1'b1;
                n_state = B_SHRINK;
            end
            B_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.smoothed   = i_div_rsp.quotient;
                    n_out.end_of_run = r_res_end;
                    if (r_flush) begin
                        if (r_left == HW_W'(1)) begin
                            n_sum   = '0;
                            n_fill  = '0;
                            n_flush = 1'b0;
                            n_state = B_IDLE;
                        end else begin
                            n_left  = r_left - 1'b1;
                            n_state = B_SHRINK;
                        end
                    end else if (r_last) begin
                        if (r_n == '0) begin
                            n_sum   = '0;
                            n_fill  = '0;
                            n_state = B_IDLE;
                        end else begin
                            n_flush = 1'b1;
                            n_left  = r_n;
                            n_state = B_SHRINK;
                        end
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_flush     <= 1'b0;
            r_left      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ws        <= n_ws;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_flush     <= n_flush;
            r_left      <= n_left;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scaled  <= n_scaled;
        r_last    <= n_last;
        r_res_end <= n_res_end;
        r_out     <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_fill_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= {r_n, 1'b1})
        else $error("window fill beyond span");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> (o_div_req.divisor != '0))
        else $error("division by an empty window");

    a_flush_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_left != '0))
        else $error("flush running with nothing owed");

    a_no_insert_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WRITE) |-> !r_flush)
        else $error("bin inserted during flush");

endmodule

### design/spectrum_scale_and_smooth_core.sv
// Scales each power-spectrum bin by an unsigned Q16.16 gain (saturating at
// 32 bits) and emits the truncated mean of the scaled bins within +/- n
// neighbors, the window clipped at both ends of the spectrum. Output i
// leaves once bin i+n has arrived; the bin flagged is_last releases the
// outputs still owed, at most n, the last of them flagged end_of_run. The
// half width n is sampled at the first bin of each spectrum. A two-stage
// input front (register, multiply) feeds a four-entry queue, so up to
// about six bins are taken in ahead of the smoothing engine. The engine
// handles one bin at a time: a bin that produces an output waits on the
// bit-serial divider (one divide per output); a bin near the spectrum
// start that produces none skips the divide. The last bin adds a divide
// for each flushed output plus a subtraction per bin removed from the
// shrinking window. The ring of scaled bins is a single RAM with one
// write and one registered read port; no clearing pass is needed after
// reset.
module spectrum_scale_and_smooth_core #(
    parameter int MAX_HALF_WIDTH = sss_pkg::DEF_MAX_HALF_WIDTH,
    parameter int RING_DEPTH     = sss_pkg::DEF_RING_DEPTH,
    parameter int INDEX_BITS     = sss_pkg::DEF_INDEX_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  sss_pkg::t_in_item              i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output sss_pkg::t_out_item             o_item,
    input  logic                           i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sss_pkg::GAIN_W-1:0]     i_cfg_data
);
    import sss_pkg::*;

    logic [HW_W-1:0]   r_half_width;
    logic [GAIN_W-1:0] r_gain;

    logic              push;
    t_task             push_task;
    logic              q_full;
    logic              q_valid;
    t_task             q_task;
    logic              q_pop;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= DEF_HALF_WIDTH;
            r_gain       <= DEF_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_WIDTH: r_half_width <= i_cfg_data[HW_W-1:0];
                CFG_GAIN:       r_gain       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sss_front #(
        .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
        .RING_DEPTH    (RING_DEPTH),
        .INDEX_BITS    (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_half_width(r_half_width),
        .i_gain      (r_gain),
        .o_push      (push),
        .o_task      (push_task),
        .i_full      (q_full)
    );

    sss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_task (push_task),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_task (q_task),
        .i_pop  (q_pop)
    );

    sss_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    sss_back #(
        .RING_DEPTH(RING_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_task (q_task),
        .o_q_pop  (q_pop),
        .o_div_req(div_req),
        .i_div_rsp(div_rsp),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule

### test/spectrum_scale_and_smooth_core_test.sv
module spectrum_scale_and_smooth_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sss_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_BINS   = 360;
    localparam int RING          = DEF_RING_DEPTH;
    localparam int HALF_CAP      = (DEF_MAX_HALF_WIDTH < (RING - 1) / 2) ?
                                   DEF_MAX_HALF_WIDTH : (RING - 1) / 2;
    localparam int COUNT_CAP     = (1 << DEF_INDEX_BITS) - 1;

    // Tracks scaled bins and the running window, queues the means they release
    class smooth_scoreboard;
        logic [DATA_W-1:0] ring [RING];
        logic [SUM_W-1:0]  window_sum;
        int                seen;
        int                slot;
        int                run_half;
        logic [HW_W-1:0]   half_width;
        logic [GAIN_W-1:0] gain;
        t_out_item         pending_means [$];
        int                errors;

        function new();
            window_sum = '0;
            seen       = 0;
            slot       = 0;
            run_half   = 0;
            half_width = DEF_HALF_WIDTH;
            gain       = DEF_GAIN;
            errors     = 0;
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                CFG_HALF_WIDTH: half_width = data[HW_W-1:0];
                CFG_GAIN:       gain = data;
                default: ;
            endcase
        endfunction

        function void note_bin(t_in_item bin);
            logic [2*DATA_W-1:0] product;
            logic [DATA_W-1:0]   scaled;
            t_out_item           mean;
            int                  n;
            int                  span;
            int                  cnt;
            int                  w;
            int                  p;
            int                  newest;
            int                  maxage;
            int                  age;

            // scale by Q16.16 gain, saturate to 32 bits
            product = ({{GAIN_W{1'b0}}, bin.power} * {{DATA_W{1'b0}}, gain}) >> GAIN_FRAC;
            scaled  = (|product[2*DATA_W-1:DATA_W]) ? '1 : product[DATA_W-1:0];

            // latch the width at the first bin of a spectrum
            if (seen == 0) begin
                run_half = (int'(half_width) > HALF_CAP) ? HALF_CAP : int'(half_width);
            end
            n    = run_half;
            span = 2 * n + 1;

            // drop the bin leaving the window, add the new one
            if (seen >= span) begin
                window_sum -= SUM_W'(ring[(slot + RING - span) % RING]);
            end
            ring[slot] = scaled;
            window_sum += SUM_W'(scaled);
            newest = slot;
            slot   = (slot + 1) % RING;
            if (seen < COUNT_CAP) seen++;

            cnt = seen;
            w   = (cnt < span) ? cnt : span;
            p   = (cnt > n) ? n : cnt;

            if (cnt > n) begin
                mean.smoothed   = DATA_W'(window_sum / SUM_W'(w));
                mean.end_of_run = bin.is_last && (p == 0);
                pending_means.push_back(mean);
            end

            // flush the owed outputs, shrinking the window from the old side
            if (bin.is_last) begin
                for (int j = 0; j < p; j++) begin
                    maxage = p - 1 - j + n;
                    if (maxage > cnt - 1) maxage = cnt - 1;
                    while (w - 1 > maxage) begin
                        age = (w - 1) % RING;
                        window_sum -= SUM_W'(ring[(newest + RING - age) % RING]);
                        w--;
                    end
                    mean.smoothed   = DATA_W'(window_sum / SUM_W'(w));
                    mean.end_of_run = (j == p - 1);
                    pending_means.push_back(mean);
                end
                window_sum = '0;
                seen       = 0;
            end
        endfunction

        function void check_mean(t_out_item got);
            t_out_item want;
            if (pending_means.size() == 0) begin
                $display("%0t: result with none expected: smoothed=%h end_of_run=%b",
                         $time, got.smoothed, got.end_of_run);
                errors++;
                return;
            end
            want = pending_means.pop_front();
            if (got.smoothed !== want.smoothed) begin
                $display("%0t: smoothed mismatch: expected %h, actual %h",
                         $time, want.smoothed, got.smoothed);
                errors++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $display("%0t: end_of_run mismatch: expected %b, actual %b",
                         $time, want.end_of_run, got.end_of_run);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_in_item             i_item;
    logic                 o_valid;
    logic                 i_stall;
    t_out_item            o_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;

    smooth_scoreboard sb;
    bit               calm;
    int               bins_sent;

    spectrum_scale_and_smooth_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop for a hung block
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [DATA_W-1:0] draw_power();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(0, 255));
            3, 4:    return DATA_W'($urandom_range(0, 65535));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Present one bin after a random gap, hold it until taken
    task automatic send_bin(input logic [DATA_W-1:0] power, input logic is_last);
        int       gap;
        t_in_item bin;
        gap         = calm ? 0 : $urandom_range(0, 7);
        bin.power   = power;
        bin.is_last = is_last;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= bin;
        do @(posedge i_clk); while (o_stall);
        sb.note_bin(bin);
        bins_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Hold off input until every mean is back, then let the engine go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stall ahead of each item
    initial begin
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_mean(o_item);
        end
    end

    initial begin
        logic [HW_W-1:0]   width;
        logic [GAIN_W-1:0] gain_val;
        int                len;
        int                target;

        sb        = new();
        calm      = 1'b0;
        bins_sent = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_HALF_WIDTH;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no smoothing, unit gain; extremes and a single bin
        send_bin('0, 1'b0);
        send_bin('1, 1'b1);
        send_bin(32'd1, 1'b1);
        settle();

        // full-scale gain saturates the scaled bin
        write_reg(CFG_GAIN, '1);
        send_bin('1, 1'b0);
        send_bin(32'd1, 1'b0);
        send_bin(32'h0001_0000, 1'b1);
        settle();

        // zero gain, narrow window
        write_reg(CFG_GAIN, '0);
        write_reg(CFG_HALF_WIDTH, GAIN_W'(1));
        send_bin(32'd5, 1'b0);
        send_bin(32'd7, 1'b1);
        settle();

        // widest window on short and single-bin spectra: clipped on both sides
        write_reg(CFG_GAIN, 32'h0001_8000);
        write_reg(CFG_HALF_WIDTH, GAIN_W'(31));
        send_bin('1, 1'b0);
        send_bin('1, 1'b0);
        send_bin(32'd3, 1'b1);
        send_bin(32'd12345, 1'b1);
        settle();

        // width written mid-spectrum takes effect from the next spectrum
        write_reg(CFG_GAIN, DEF_GAIN);
        write_reg(CFG_HALF_WIDTH, GAIN_W'(2));
        send_bin(32'd10, 1'b0);
        send_bin(32'd20, 1'b0);
        send_bin(32'd30, 1'b0);
        send_bin(32'd40, 1'b0);
        settle();
        write_reg(CFG_HALF_WIDTH, GAIN_W'(5));
        send_bin(32'd50, 1'b0);
        send_bin(32'd60, 1'b0);
        send_bin(32'd70, 1'b1);
        for (int k = 0; k < 5; k++) send_bin(draw_power(), k == 4);
        settle();

        // random phases: new setting, a few spectra, then drain
        target = bins_sent + RANDOM_BINS;
        while (bins_sent < target) begin
            case ($urandom_range(0, 4))
                0:       width = '0;
                1:       width = '1;
                2:       width = HW_W'($urandom_range(1, 3));
                default: width = HW_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       gain_val = '0;
                1:       gain_val = '1;
                2:       gain_val = DEF_GAIN;
                3:       gain_val = $urandom;
                default: gain_val = $urandom_range(1, 32'h0004_0000);
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(CFG_HALF_WIDTH, GAIN_W'(width));
            if ($urandom_range(0, 3) != 0) write_reg(CFG_GAIN, gain_val);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 12);
                    6, 7:             len = $urandom_range(13, 40);
                    default:          len = $urandom_range(41, 90);
                endcase
                for (int k = 0; k < len; k++) send_bin(draw_power(), k == len - 1);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_means.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
design/sss_pkg.sv
design/sss_ram.sv
design/sss_div.sv
design/sss_queue.sv
design/sss_front.sv
design/sss_back.sv
design/spectrum_scale_and_smooth_core.sv
test/spectrum_scale_and_smooth_core_test.sv
